@@ rtl/mexp_pkg.sv @@
// Shared types and constants of the modular exponentiation block.
`default_nettype none
package mexp_pkg;
  localparam int unsigned PayloadBits  = 62;
  localparam int unsigned ExponentBits = 63;
  localparam int unsigned TdataBits    = 64;

  typedef enum logic [0:0] {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_index_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RED  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SQR  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } mul_ctrl_t;
endpackage
`default_nettype wire

@@ rtl/mexp_cell.sv @@
// One cell of the multiplier bit chain: holds one bit and hands it to its neighbour.
`default_nettype none
module mexp_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic next_bit_i,
  output logic bit_o
);
  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;
endmodule
`default_nettype wire

@@ rtl/mexp_mulmod.sv @@
// Interleaved shift-add-reduce modular multiplier, one multiplier bit a cycle.
`default_nettype none
module mexp_mulmod #(
  parameter int unsigned N = 62
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] x_i,
  input  logic [N-1:0] y_i,
  input  logic [N-1:0] m_i,
  output logic         done_o,
  output logic [N-1:0] prod_o
);
  localparam int unsigned CntBits = $clog2(N);
  localparam logic [CntBits-1:0] CntLast = CntBits'(N - 1);

  logic               busy_q, busy_d, done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [N-1:0]       acc_q, acc_d, add_q, add_d;
  logic [N:0]         sum, dbl;
  logic [N-1:0]       chain;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic nb;
    if (k == N - 1) begin : g_end
      assign nb = 1'b0;
    end else begin : g_mid
      assign nb = chain[k+1];
    end
    mexp_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (start_i),
      .shift_i    (busy_q),
      .load_bit_i (y_i[k]),
      .next_bit_i (nb),
      .bit_o      (chain[k])
    );
  end

  always_comb begin
    sum    = {1'b0, acc_q} + {1'b0, add_q};
    dbl    = {add_q, 1'b0};
    acc_d  = acc_q;
    add_d  = add_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      add_d  = x_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (chain[0]) begin
        acc_d = (sum >= {1'b0, m_i}) ? N'(sum - {1'b0, m_i}) : sum[N-1:0];
      end
      add_d = (dbl >= {1'b0, m_i}) ? N'(dbl - {1'b0, m_i}) : dbl[N-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    add_q <= add_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

@@ rtl/modular_exponentiation_top.sv @@
// Top level of the modular exponentiation block: control and configuration.
//
// Computes message ^ exponent mod modulus for each request on the slave
// stream (s_axis_*); one result per request leaves on the master stream
// (m_axis_*). Exponent (index 0) and modulus (index 1) are written through
// the cfg_* channel, which is always ready; write only while idle.
// One request is worked on at a time: s_axis_tready is high only when the
// controller is idle. A request first reduces the message mod the modulus;
// then, for each exponent bit up to its highest set bit, there is a check,
// a multiplication where the bit is set, and a squaring; a last check and
// the load of the output register follow. The multiplier is bit-serial,
// built on a chain of cells. A modulus of zero or one returns 0.
// The result sits in an output register; if the receiver stalls it holds
// there, the next request may be taken meanwhile and completes once the
// register is free.
// Reset restores exponent 1 and modulus 1 and empties the output register.
`default_nettype none
module modular_exponentiation_top #(
  parameter int unsigned OPERAND_BITS = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // message[61:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // power_result[61:0], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  mexp_pkg::cfg_index_e cfg_index_i,
  input  logic [62:0] cfg_data_i
);
  import mexp_pkg::*;

  localparam int unsigned N = OPERAND_BITS;
  localparam int unsigned CntBits = $clog2(N);
  localparam logic [CntBits-1:0] CntLast = CntBits'(N - 1);

  state_e                  st_q, st_d;
  logic [ExponentBits-1:0] exp_cfg_q, e_q, e_d;
  logic [PayloadBits-1:0]  mod_cfg_q;
  logic [N-1:0]            m_q, m_d, base_q, base_d, acc_q, acc_d, msg_q, msg_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic                    iss_q, iss_d;
  logic                    ov_q, ov_d;
  logic [PayloadBits-1:0]  od_q, od_d, res_ext;
  logic [N:0]              rd;
  logic [N-1:0]            prod, mul_x;
  logic [N-1:0]            in_mod;
  mul_ctrl_t               mc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_mod        = mod_cfg_q[N-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cfg_q <= ExponentBits'(1);
      mod_cfg_q <= PayloadBits'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EXPONENT: exp_cfg_q <= cfg_data_i;
        CFG_MODULUS:  mod_cfg_q <= cfg_data_i[PayloadBits-1:0];
        default:      exp_cfg_q <= exp_cfg_q;
      endcase
    end
  end

  assign mc.start = ((st_q == ST_MUL) || (st_q == ST_SQR)) && !iss_q;
  assign mul_x    = (st_q == ST_MUL) ? acc_q : base_q;

  mexp_mulmod #(.N(N)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mc.start),
    .x_i     (mul_x),
    .y_i     (base_q),
    .m_i     (m_q),
    .done_o  (mc.done),
    .prod_o  (prod)
  );

  always_comb begin
    res_ext        = '0;
    res_ext[N-1:0] = acc_q;
    rd     = {base_q, msg_q[N-1]};
    st_d   = st_q;
    e_d    = e_q;
    m_d    = m_q;
    base_d = base_q;
    acc_d  = acc_q;
    msg_d  = msg_q;
    cnt_d  = cnt_q;
    iss_d  = iss_q;
    ov_d   = ov_q;
    od_d   = od_q;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          m_d    = in_mod;
          e_d    = exp_cfg_q;
          msg_d  = s_axis_tdata[N-1:0];
          base_d = '0;
          cnt_d  = '0;
          if (in_mod <= N'(1)) begin
            acc_d = '0;
            st_d  = ST_DONE;
          end else begin
            acc_d = N'(1);
            st_d  = ST_RED;
          end
        end
      end
      ST_RED: begin
        base_d = (rd >= {1'b0, m_q}) ? N'(rd - {1'b0, m_q}) : rd[N-1:0];
        msg_d  = {msg_q[N-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          st_d = ST_CHK;
        end
      end
      ST_CHK: begin
        iss_d = 1'b0;
        if (e_q == '0) begin
          st_d = ST_DONE;
        end else if (e_q[0]) begin
          st_d = ST_MUL;
        end else begin
          st_d = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mc.start) begin
          iss_d = 1'b1;
        end
        if (mc.done) begin
          acc_d = prod;
          iss_d = 1'b0;
          st_d  = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mc.start) begin
          iss_d = 1'b1;
        end
        if (mc.done) begin
          base_d = prod;
          e_d    = e_q >> 1;
          iss_d  = 1'b0;
          st_d   = ST_CHK;
        end
      end
      ST_DONE: begin
        if (!ov_q) begin
          od_d = res_ext;
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      iss_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      iss_q <= iss_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    m_q    <= m_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    msg_q  <= msg_d;
    od_q   <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = TdataBits'(od_q);
endmodule
`default_nettype wire
